>>> rtl/ppbd_pkg.sv
// shared types and constants of the pulse peak and heart-rate detector
package ppbd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int TIME_W     = 32;
	localparam int RAW_W      = 21;
	localparam int AVG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int RATE_NUM_W = 24;

	// 60000 bpm-ms in q8.8
	localparam logic [RATE_NUM_W-1:0] RATE_NUMERATOR = 24'd15360000;
	localparam logic [TIME_W-1:0]     MIN_INTERVAL   = 32'd10;
	localparam logic [RAW_W-1:0]      RATE_LOW_Q88   = 21'd10240;
	localparam logic [RAW_W-1:0]      RATE_HIGH_Q88  = 21'd33280;

	localparam logic [SAMPLE_W-1:0] MIN_TH_RESET = 16'd20;
	localparam logic [SAMPLE_W-1:0] MAX_TH_RESET = 16'd2000;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TH = 1'd1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RISE = 2'd1,
		PH_FALL = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RATE,
		S_RING_RD,
		S_RING_UPD,
		S_MEAN,
		S_OUT
	} seq_state_t;

endpackage

>>> rtl/ppbd_if.sv
// request channels: incoming samples and outgoing beat results
interface ppbd_sample_if;
	import ppbd_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0]          time_ms;

	modport source (output valid, sample, time_ms, input ready);
	modport sink (input valid, sample, time_ms, output ready);
endinterface

interface ppbd_result_if;
	import ppbd_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       beat_found;
	logic                       beat_in_range;
	logic [RAW_W-1:0]           raw_rate;
	logic [AVG_W-1:0]           average_rate;
	logic signed [SAMPLE_W-1:0] peak_level;

	modport source (output valid, beat_found, beat_in_range, raw_rate, average_rate,
		peak_level, input ready);
	modport sink (input valid, beat_found, beat_in_range, raw_rate, average_rate,
		peak_level, output ready);
endinterface

>>> rtl/ppbd_ram.sv
// generic single-port-write ram with registered read
module ppbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/ppbd_div.sv
// serial restoring divider, one quotient bit per cycle
module ppbd_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] nq_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// dividend bits shift out the top while quotient bits shift in below
	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = nq_q;
endmodule

>>> rtl/pulse_peak_bpm_detector.sv
// top level: pulse peak tracker, beat rate and windowed rate average
//
// samples: one request per filtered pulse sample with its millisecond timestamp.
// results: exactly one request per sample: beat flag, in-range flag, raw rate,
//   window average and latest peak level; raw rate in unsigned q13.8, average in unsigned q8.8.
// cfg: write enable, register index (0 lower threshold, 1 upper threshold) and
//   16-bit data; to be written only while the block is idle, which it does not enforce.
// A sample that closes no beat is accepted, evaluated and loaded into the output
//   register. A beat runs the 24-step serial divider once for the rate and, when
//   the ring is not empty, once more for the mean, with one ring update for an
//   in-range rate and one extra read once the ring is full; the two divisions
//   share one divider.
// The rate ring sits in a small ram read in the cycle before the write that
//   replaces the oldest entry.
// Reset clears the tracker, the ring count and total and the thresholds to 20
//   and 2000; ring contents stay unknown and are only read once refilled.
// The output register holds a result until taken; the next sample is accepted
//   meanwhile and its result waits in the sequencer.
module pulse_peak_bpm_detector #(
	parameter int WINDOW_SIZE = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ppbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppbd_pkg::SAMPLE_W-1:0]  cfg_data,
	ppbd_sample_if.sink                    samples,
	ppbd_result_if.source                  results
);
	import ppbd_pkg::*;

	localparam int PW      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int FW      = $clog2(WINDOW_SIZE + 1);
	localparam int TOTAL_W = AVG_W + $clog2(WINDOW_SIZE);
	localparam int DIV_NW  = (TOTAL_W > RATE_NUM_W) ? TOTAL_W : RATE_NUM_W;

	seq_state_t state_q, state_nxt;

	logic signed [SAMPLE_W-1:0] min_th_q, max_th_q;
	phase_t                     phase_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic [TIME_W-1:0]          cand_q, last_q;
	logic signed [SAMPLE_W-1:0] peak_q;
	logic [PW-1:0]              pos_q;
	logic [FW-1:0]              fill_q;
	logic [TOTAL_W-1:0]         total_q;
	logic [AVG_W-1:0]           mean_q;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]          time_q;
	logic                       res_found_q, res_in_range_q;
	logic [RAW_W-1:0]           res_raw_q;

	logic                       out_valid_q;
	logic                       out_found_q, out_in_range_q;
	logic [RAW_W-1:0]           out_raw_q;
	logic [AVG_W-1:0]           out_avg_q;
	logic signed [SAMPLE_W-1:0] out_peak_q;

	logic                div_start, div_done;
	logic [DIV_NW-1:0]   div_num, div_quo;
	logic [TIME_W-1:0]   div_den;
	logic                ram_re, ram_we;
	logic [AVG_W-1:0]    ram_rdata, ring_wdata;
	logic                out_load;

	logic                over, rising, beat_go, rate_ok, ring_full;
	logic [TIME_W-1:0]   interval;
	logic [RAW_W-1:0]    quo_raw;
	logic [TOTAL_W-1:0]  new_total;
	logic [FW-1:0]       new_fill;

	assign over      = sample_q > max_th_q;
	assign rising    = sample_q > prev_q;
	assign interval  = cand_q - last_q;
	assign beat_go   = !over && (phase_q == PH_RISE) && !rising && (cand_q > last_q)
		&& (interval > MIN_INTERVAL);
	assign quo_raw   = div_quo[RAW_W-1:0];
	assign rate_ok   = (quo_raw > RATE_LOW_Q88) && (quo_raw < RATE_HIGH_Q88);
	assign ring_full = fill_q == FW'(WINDOW_SIZE);
	assign ring_wdata = res_raw_q[AVG_W-1:0];

	// a full ring drops its oldest entry, read from the ram in the cycle before
	always_comb begin
		if (ring_full) begin
			new_total = total_q - TOTAL_W'(ram_rdata) + TOTAL_W'(ring_wdata);
			new_fill  = fill_q;
		end else begin
			new_total = total_q + TOTAL_W'(ring_wdata);
			new_fill  = fill_q + FW'(1);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (samples.valid) state_nxt = S_EVAL;
			end
			S_EVAL: begin
				state_nxt = beat_go ? S_RATE : S_OUT;
			end
			S_RATE: begin
				if (div_done) begin
					if (rate_ok) state_nxt = ring_full ? S_RING_RD : S_RING_UPD;
					else state_nxt = (fill_q != '0) ? S_MEAN : S_OUT;
				end
			end
			S_RING_RD: begin
				state_nxt = S_RING_UPD;
			end
			S_RING_UPD: begin
				state_nxt = S_MEAN;
			end
			S_MEAN: begin
				if (div_done) state_nxt = S_OUT;
			end
			S_OUT: begin
				if (out_load) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		samples.ready = 1'b0;
		div_start     = 1'b0;
		div_num       = DIV_NW'(RATE_NUMERATOR);
		div_den       = interval;
		ram_re        = 1'b0;
		ram_we        = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				samples.ready = 1'b1;
			end
			S_EVAL: begin
				div_start = beat_go;
			end
			S_RATE: begin
				if (div_done && !rate_ok && (fill_q != '0)) begin
					div_start = 1'b1;
					div_num   = DIV_NW'(total_q);
					div_den   = TIME_W'(fill_q);
				end
			end
			S_RING_RD: begin
				ram_re = 1'b1;
			end
			S_RING_UPD: begin
				ram_we    = 1'b1;
				div_start = 1'b1;
				div_num   = DIV_NW'(new_total);
				div_den   = TIME_W'(new_fill);
			end
			S_OUT: begin
				out_load = !out_valid_q || results.ready;
			end
			default: begin
				samples.ready = 1'b0;
			end
		endcase
	end

	ppbd_div #(
		.NUM_W (DIV_NW),
		.DEN_W (TIME_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ppbd_ram #(
		.WIDTH (AVG_W),
		.DEPTH (WINDOW_SIZE)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (ring_wdata),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_th_q    <= MIN_TH_RESET;
			max_th_q    <= MAX_TH_RESET;
			phase_q     <= PH_IDLE;
			prev_q      <= '0;
			cand_q      <= '0;
			last_q      <= '0;
			peak_q      <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			mean_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_TH: min_th_q <= cfg_data;
					CFG_MAX_TH: max_th_q <= cfg_data;
					default: min_th_q <= min_th_q;
				endcase
			end
			if (state_q == S_EVAL) begin
				if (over) begin
					phase_q <= PH_IDLE;
					prev_q  <= '0;
					cand_q  <= '0;
					last_q  <= '0;
					peak_q  <= '0;
					total_q <= '0;
					fill_q  <= '0;
				end else begin
					case (phase_q)
						PH_RISE: begin
							if (rising) begin
								cand_q <= time_q;
								peak_q <= sample_q;
								prev_q <= sample_q;
							end else if (beat_go) begin
								// closing sample leaves the previous sample as is
								last_q  <= cand_q;
								phase_q <= PH_FALL;
							end else begin
								prev_q <= sample_q;
							end
						end
						PH_FALL: begin
							if (sample_q < min_th_q) phase_q <= PH_IDLE;
							prev_q <= sample_q;
						end
						default: begin
							if (sample_q >= min_th_q) phase_q <= PH_RISE;
							prev_q <= sample_q;
						end
					endcase
				end
			end
			if (state_q == S_RING_UPD) begin
				total_q <= new_total;
				fill_q  <= new_fill;
				pos_q   <= (pos_q == PW'(WINDOW_SIZE - 1)) ? '0 : pos_q + PW'(1);
			end
			if ((state_q == S_MEAN) && div_done) begin
				mean_q <= div_quo[AVG_W-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_q <= samples.sample;
			time_q   <= samples.time_ms;
		end
		if (state_q == S_EVAL) begin
			res_found_q    <= beat_go;
			res_in_range_q <= 1'b0;
			res_raw_q      <= '0;
		end
		if ((state_q == S_RATE) && div_done) begin
			res_raw_q      <= quo_raw;
			res_in_range_q <= rate_ok;
		end
		if (out_load) begin
			out_found_q    <= res_found_q;
			out_in_range_q <= res_in_range_q;
			out_raw_q      <= res_raw_q;
			out_avg_q      <= mean_q;
			out_peak_q     <= peak_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.beat_found    = out_found_q;
	assign results.beat_in_range = out_in_range_q;
	assign results.raw_rate      = out_raw_q;
	assign results.average_rate  = out_avg_q;
	assign results.peak_level    = out_peak_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_SIZE))
		else $error("ring count beyond window");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output step");

	a_ring_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (res_in_range_q && (res_raw_q > RATE_LOW_Q88) && (res_raw_q < RATE_HIGH_Q88)))
		else $error("out-of-range rate written to ring");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_RATE) || (state_q == S_MEAN)))
		else $error("divider finished with no waiting step");
endmodule
